// ===== rtl/pte_pkg.sv =====
// Shared types and constants of the prefix tree engine.
// Used by the request interface, the controller, the datapath and the top level.
`default_nettype none

package pte_pkg;

	// Default pool and alphabet sizes.
	localparam int MAX_NODES_DEF     = 1024;
	localparam int ALPHABET_SIZE_DEF = 26;

	// Field widths of the request channel.
	localparam int CMD_W    = 2;
	localparam int LETTER_W = 5;

	// Command codes; the fourth code is unused and ignored.
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_MARK,
		ST_EMIT
	} pte_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic accept;
		logic eval;
		logic finish_mark;
		logic emit;
	} pte_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
		logic cmd_ok;
		logic last;
		logic search;
		logic out_free;
	} pte_stat_t;

	// True for the three command codes that have a meaning.
	function automatic logic cmd_known(input logic [CMD_W-1:0] c);
		return (c == CMD_INSERT) || (c == CMD_SEARCH) || (c == CMD_PREFIX);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pte_item_if.sv =====
// Request channel of the prefix tree engine: one letter with its command.
// Depends on pte_pkg for the field widths.
`default_nettype none

interface pte_item_if import pte_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [LETTER_W-1:0] letter;
	logic                last;

	modport source (output valid, output command, output letter, output last, input ready);
	modport sink   (input valid, input command, input letter, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/pte_result_if.sv =====
// Result channel of the prefix tree engine: answer and status of one word.
// Stand-alone interface with fixed one-bit fields.
`default_nettype none

interface pte_result_if ();
	logic valid;
	logic ready;
	logic answer;
	logic status;

	modport source (output valid, output answer, output status, input ready);
	modport sink   (input valid, input answer, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/pte_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module pte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pte_ctrl.sv =====
// Controller state machine of the prefix tree engine.
// Depends on pte_pkg; drives the datapath through pte_ctrl_t commands.
`default_nettype none

module pte_ctrl import pte_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire pte_stat_t stat,
	output pte_ctrl_t      ctrl
);

	pte_state_t state_q;
	pte_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clear_done) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid && stat.cmd_ok) begin
					state_next = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!stat.last) begin
					state_next = ST_IDLE;
				end else if (stat.search) begin
					state_next = ST_MARK;
				end else begin
					state_next = ST_EMIT;
				end
			end
			ST_MARK: begin
				state_next = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		ctrl       = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctrl.clear = 1'b1;
			end
			ST_IDLE: begin
				item_ready  = 1'b1;
				ctrl.accept = item_valid;
			end
			ST_EVAL: begin
				ctrl.eval = 1'b1;
			end
			ST_MARK: begin
				ctrl.finish_mark = 1'b1;
			end
			ST_EMIT: begin
				ctrl.emit = stat.out_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/pte_dp.sv =====
// Datapath of the prefix tree engine: walk registers, node pool, both tables
// and the result register. Depends on pte_pkg and pte_ram.
`default_nettype none

module pte_dp import pte_pkg::*; #(
	parameter int MAX_NODES     = MAX_NODES_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pte_ctrl_t           ctrl,
	output pte_stat_t                stat,
	input  wire logic [CMD_W-1:0]    item_command,
	input  wire logic [LETTER_W-1:0] item_letter,
	input  wire logic                item_last,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output logic                     result_answer,
	output logic                     result_status
);

	localparam int DEPTH = MAX_NODES * ALPHABET_SIZE;
	localparam int SAW   = $clog2(DEPTH);
	localparam int NW    = $clog2(MAX_NODES);
	localparam int NUW   = $clog2(MAX_NODES + 1);

	// Walk and pool state.
	logic [NW-1:0]  walk_q;
	logic           failed_q;
	logic           ovf_q;
	logic [NUW-1:0] used_q;
	logic [SAW-1:0] clr_q;

	// Registered request.
	logic [CMD_W-1:0] cmd_q;
	logic             last_q;
	logic             code_ok_q;
	logic [SAW-1:0]   slot_q;

	// Result held until the output stage is free.
	logic res_answer_q;
	logic res_status_q;

	// Output stage.
	logic out_valid_q;
	logic out_answer_q;
	logic out_status_q;

	logic           code_ok_in;
	logic [SAW-1:0] slot_in;
	logic [NW-1:0]  child_rd;
	logic           mark_rd;
	logic           alloc;
	logic           fail_new;
	logic           ovf_new;
	logic [NW-1:0]  walk_new;
	logic           clear_mark;
	logic           set_mark;
	logic           word_done;

	// Table slot of the incoming letter below the current node.
	always_comb begin
		code_ok_in = (32'(item_letter) < ALPHABET_SIZE);
		slot_in    = '0;
		if (code_ok_in) begin
			slot_in = SAW'(SAW'(walk_q) * SAW'(ALPHABET_SIZE)) + SAW'(item_letter);
		end
	end

	// One step of the walk, using the child read at request time. A node is
	// created only in the evaluate cycle of the request.
	always_comb begin
		alloc    = 1'b0;
		fail_new = failed_q;
		ovf_new  = ovf_q;
		walk_new = walk_q;
		if (!failed_q) begin
			if (!code_ok_q) begin
				fail_new = 1'b1;
			end else if (child_rd == '0) begin
				if ((cmd_q == CMD_INSERT) && (used_q < NUW'(MAX_NODES))) begin
					alloc    = ctrl.eval;
					walk_new = used_q[NW-1:0];
				end else begin
					if (cmd_q == CMD_INSERT) begin
						ovf_new = 1'b1;
					end
					fail_new = 1'b1;
				end
			end else begin
				walk_new = child_rd;
			end
		end
	end

	assign word_done  = ctrl.eval && last_q && (cmd_q != CMD_SEARCH);
	assign set_mark   = ctrl.eval && last_q && (cmd_q == CMD_INSERT) && !fail_new;
	assign clear_mark = ctrl.clear && (clr_q < SAW'(MAX_NODES));

	// Child table: cleared by the sweep, written when a node is created.
	pte_ram #(
		.WIDTH (NW),
		.DEPTH (DEPTH)
	) u_child_ram (
		.clk     (clk),
		.wr_en   (ctrl.clear || alloc),
		.wr_addr (ctrl.clear ? clr_q : slot_q),
		.wr_data (ctrl.clear ? '0 : used_q[NW-1:0]),
		.rd_en   (ctrl.accept),
		.rd_addr (slot_in),
		.rd_data (child_rd)
	);

	// Word end marks: cleared by the sweep, set by a finished insert.
	pte_ram #(
		.WIDTH (1),
		.DEPTH (MAX_NODES)
	) u_mark_ram (
		.clk     (clk),
		.wr_en   (clear_mark || set_mark),
		.wr_addr (ctrl.clear ? clr_q[NW-1:0] : walk_new),
		.wr_data (!ctrl.clear),
		.rd_en   (ctrl.eval),
		.rd_addr (walk_new),
		.rd_data (mark_rd)
	);

	// Clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctrl.clear && !stat.clear_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_q     <= item_command;
			last_q    <= item_last;
			code_ok_q <= code_ok_in;
			slot_q    <= slot_in;
		end
	end

	// Walk state and node count; a finished word returns to the root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q   <= '0;
			failed_q <= 1'b0;
			ovf_q    <= 1'b0;
			used_q   <= NUW'(1);
		end else begin
			if (alloc) begin
				used_q <= used_q + 1'b1;
			end
			if (word_done || ctrl.finish_mark) begin
				walk_q   <= '0;
				failed_q <= 1'b0;
				ovf_q    <= 1'b0;
			end else if (ctrl.eval) begin
				walk_q   <= walk_new;
				failed_q <= fail_new;
				ovf_q    <= ovf_new;
			end
		end
	end

	// Result of the finished word.
	always_ff @(posedge clk) begin
		if (word_done) begin
			res_answer_q <= !fail_new;
			res_status_q <= ovf_new;
		end else if (ctrl.finish_mark) begin
			res_answer_q <= !failed_q && mark_rd;
			res_status_q <= ovf_q;
		end
	end

	// Output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_answer_q <= res_answer_q;
			out_status_q <= res_status_q;
		end
	end

	assign result_valid  = out_valid_q;
	assign result_answer = out_answer_q;
	assign result_status = out_status_q;

	// Status to the controller.
	always_comb begin
		stat.clear_done = (clr_q == SAW'(DEPTH - 1));
		stat.cmd_ok     = cmd_known(item_command);
		stat.last       = last_q;
		stat.search     = (cmd_q == CMD_SEARCH);
		stat.out_free   = !out_valid_q || result_ready;
	end

endmodule

`default_nettype wire

// ===== rtl/prefix_tree_engine.sv =====
// Prefix tree engine: top level joining the controller and the datapath.
// Depends on pte_pkg, pte_item_if, pte_result_if, pte_ctrl and pte_dp.
//
// Each request carries one letter of a word with its command (insert, exact
// search or prefix test) and a flag on the final letter; one result follows
// each final letter. After reset the block sweeps the child table, one entry
// a cycle, over all MAX_NODES * ALPHABET_SIZE entries (26624 by default), and
// takes no request until the sweep is done. A letter then has a child-table
// read issued when the request is accepted and an evaluate step that follows
// or creates the child. On the final letter of an insert or prefix test the
// evaluate step also loads the result register; a search loads it in the
// mark state after, from the word end mark of the node reached. A result
// waiting at the output holds up the next final letter only, not the letters
// before it. Requests with the unused command code are taken and dropped.
`default_nettype none

module prefix_tree_engine import pte_pkg::*; #(
	parameter int MAX_NODES     = MAX_NODES_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pte_item_if.sink    item,
	pte_result_if.source result
);

	pte_ctrl_t ctrl;
	pte_stat_t stat;

	// Controller.
	pte_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.stat       (stat),
		.ctrl       (ctrl)
	);

	// Datapath.
	pte_dp #(
		.MAX_NODES     (MAX_NODES),
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.item_command  (item.command),
		.item_letter   (item.letter),
		.item_last     (item.last),
		.result_valid  (result.valid),
		.result_ready  (result.ready),
		.result_answer (result.answer),
		.result_status (result.status)
	);

endmodule

`default_nettype wire

// ===== test/prefix_tree_engine_test.sv =====
// Self-checking testbench of the prefix tree engine: words go in one letter per
// request and each answer is compared with a software trie kept in step.
// Depends on pte_pkg, pte_item_if, pte_result_if and prefix_tree_engine.
`default_nettype none

module prefix_tree_engine_test;
	import pte_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = MAX_NODES_DEF;
	localparam int ALPHA = ALPHABET_SIZE_DEF;

	// The fourth command code, which the block takes and drops.
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam logic [CMD_W-1:0] CMD_PICK [3] = '{CMD_INSERT, CMD_SEARCH, CMD_PREFIX};

	// Highest letter code the field can carry; everything from ALPHA up is invalid.
	localparam logic [LETTER_W-1:0] LETTER_TOP = 5'd31;

	typedef struct packed {
		logic answer;
		logic status;
	} verdict_t;

	typedef struct packed {
		logic [3:0]                len;
		logic [7:0][LETTER_W-1:0] ch;
	} word_t;

	logic clk = 1'b0;
	logic arst_n;

	pte_item_if   item_ch ();
	pte_result_if res_ch ();

	prefix_tree_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch)
	);

	// Software copy of the trie.
	int unsigned trie_child [NODES*ALPHA];
	bit          trie_end [NODES];
	int unsigned trie_used;
	int unsigned walk_at;
	bit          walk_lost;
	bit          pool_overflow;

	verdict_t    verdicts_due [$];
	word_t       known_words [$];
	int unsigned mismatches = 0;
	int unsigned letters_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_len = 0;

	always #5 clk = ~clk;

	// Walks one letter through the software trie; returns 1 when a result is due.
	function automatic bit trie_step(input logic [CMD_W-1:0] cmd,
			input logic [LETTER_W-1:0] code, input logic fin, output verdict_t v);
		int unsigned slot;
		int unsigned nxt;
		v = '0;
		if (cmd == CMD_NONE)
			return 1'b0;
		if (!walk_lost) begin
			if (code >= ALPHA) begin
				walk_lost = 1'b1;
			end else begin
				slot = walk_at * ALPHA + code;
				nxt = trie_child[slot];
				if (nxt == 0 && cmd == CMD_INSERT && trie_used < NODES) begin
					nxt = trie_used;
					trie_used++;
					trie_child[slot] = nxt;
				end
				if (nxt == 0) begin
					if (cmd == CMD_INSERT)
						pool_overflow = 1'b1;
					walk_lost = 1'b1;
				end else begin
					walk_at = nxt;
				end
			end
		end
		if (!fin)
			return 1'b0;
		case (cmd)
			CMD_INSERT: begin
				if (!walk_lost) begin
					trie_end[walk_at] = 1'b1;
					v.answer = 1'b1;
				end
			end
			CMD_SEARCH: v.answer = !walk_lost && trie_end[walk_at];
			CMD_PREFIX: v.answer = !walk_lost;
			default: v.answer = 1'b0;
		endcase
		v.status = pool_overflow;
		walk_at = 0;
		walk_lost = 1'b0;
		pool_overflow = 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [LETTER_W-1:0] ltr(input byte c);
		return LETTER_W'(c - "a");
	endfunction

	// Random word; a narrow alphabet makes shared prefixes likely.
	function automatic word_t make_word(input bit narrow, input int unsigned len);
		word_t w;
		w.len = 4'(len);
		for (int i = 0; i < 8; i++)
			w.ch[i] = narrow ? LETTER_W'($urandom_range(3)) : LETTER_W'($urandom_range(ALPHA - 1));
		return w;
	endfunction

	// Mostly a word inserted earlier, otherwise a fresh one.
	function automatic word_t recall_word();
		if (known_words.size() != 0 && $urandom_range(99) < 75)
			return known_words[$urandom_range(known_words.size() - 1)];
		return make_word($urandom_range(1), $urandom_range(5, 1));
	endfunction

	function automatic void flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t ns: %s", $time, msg);
	endfunction

	// Offers one request, waits for it to be taken and books its expected result.
	task automatic send_letter(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] code,
			input logic fin);
		verdict_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.command <= cmd;
		item_ch.letter  <= code;
		item_ch.last    <= fin;
		do @(posedge clk); while (!item_ch.ready);
		if (trie_step(cmd, code, fin, v))
			verdicts_due.push_back(v);
		if (cmd != CMD_NONE)
			letters_sent++;
	endtask

	task automatic send_word(input logic [CMD_W-1:0] cmd, input word_t w);
		for (int i = 0; i < w.len; i++)
			send_letter(cmd, w.ch[i], i == w.len - 1);
	endtask

	// Lets every booked result come back, with the request channel idle.
	task automatic wait_settled();
		item_ch.valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Hand-picked words: extreme letters, every command and the corner cases.
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_letter(CMD_INSERT, ltr("z"), 1'b1);
		send_letter(CMD_INSERT, ltr("a"), 1'b1);
		// A one-letter insert on a node that already exists still marks it.
		send_letter(CMD_INSERT, ltr("a"), 1'b1);
		send_letter(CMD_SEARCH, ltr("a"), 1'b1);
		send_letter(CMD_SEARCH, ltr("z"), 1'b1);
		send_letter(CMD_INSERT, ltr("b"), 1'b0);
		send_letter(CMD_INSERT, ltr("a"), 1'b1);
		send_letter(CMD_SEARCH, ltr("b"), 1'b1);
		send_letter(CMD_PREFIX, ltr("b"), 1'b1);
		// Missing child: the rest of the word is ignored.
		send_letter(CMD_SEARCH, ltr("c"), 1'b1);
		send_letter(CMD_PREFIX, ltr("c"), 1'b0);
		send_letter(CMD_PREFIX, ltr("d"), 1'b1);
		// Letter codes past the alphabet have no child.
		send_letter(CMD_INSERT, LETTER_TOP, 1'b1);
		send_letter(CMD_SEARCH, LETTER_W'(ALPHA), 1'b1);
		send_letter(CMD_PREFIX, ltr("b"), 1'b0);
		send_letter(CMD_PREFIX, LETTER_W'(30), 1'b1);
		// The unused command is dropped, also inside a word.
		send_letter(CMD_NONE, LETTER_TOP, 1'b1);
		send_letter(CMD_PREFIX, ltr("b"), 1'b0);
		send_letter(CMD_NONE, ltr("x"), 1'b0);
		send_letter(CMD_PREFIX, ltr("a"), 1'b1);
		// Mixed commands within one word.
		send_letter(CMD_INSERT, ltr("q"), 1'b0);
		send_letter(CMD_SEARCH, ltr("r"), 1'b1);
		send_letter(CMD_SEARCH, ltr("q"), 1'b1);
		send_letter(CMD_SEARCH, ltr("b"), 1'b0);
		send_letter(CMD_INSERT, ltr("c"), 1'b1);
		wait_settled();
	endtask

	// Random words: inserts, lookups of earlier words, mixed and broken words, noise.
	task automatic test_random(input int unsigned count, input int unsigned s_pct,
			input int unsigned r_pct);
		word_t       w;
		int unsigned pick;
		int unsigned stop;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		stop = letters_sent + count;
		while (letters_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				w = make_word($urandom_range(1), ($urandom_range(9) == 0) ? 8 : $urandom_range(5, 1));
				send_word(CMD_INSERT, w);
				known_words.push_back(w);
				if (known_words.size() > 256)
					void'(known_words.pop_front());
			end else if (pick < 60) begin
				send_word(CMD_SEARCH, recall_word());
			end else if (pick < 80) begin
				w = recall_word();
				w.len = 4'($urandom_range(w.len, 1));
				send_word(CMD_PREFIX, w);
			end else if (pick < 88) begin
				w = recall_word();
				for (int i = 0; i < w.len; i++)
					send_letter(CMD_PICK[$urandom_range(2)], w.ch[i], i == w.len - 1);
			end else if (pick < 95) begin
				w = recall_word();
				w.ch[$urandom_range(w.len - 1)] = LETTER_W'($urandom_range(LETTER_TOP, ALPHA));
				send_word(CMD_PICK[$urandom_range(2)], w);
			end else begin
				send_letter(CMD_NONE, LETTER_W'($urandom_range(LETTER_TOP)), $urandom_range(1));
			end
		end
		wait_settled();
	endtask

	// The receiver stops for a long stretch while words keep coming.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_len = 400;
		for (int n = 0; n < 30; n++)
			send_word(CMD_PICK[$urandom_range(1)], recall_word());
		wait_settled();
	endtask

	// Fills the node pool, then inserts that no longer fit.
	task automatic test_pool_full();
		word_t w;
		send_idle_pct = 10;
		recv_idle_pct = 20;
		while (trie_used < NODES)
			send_word(CMD_INSERT, make_word(1'b0, 8));
		for (int n = 0; n < 12; n++)
			send_word(CMD_INSERT, make_word(1'b0, $urandom_range(4, 2)));
		// Full pool followed by an invalid letter in the same word.
		w = make_word(1'b0, 4);
		w.ch[3] = LETTER_TOP;
		send_word(CMD_INSERT, w);
		for (int n = 0; n < 12; n++)
			send_word(CMD_PICK[$urandom_range(2)], recall_word());
		send_letter(CMD_INSERT, ltr("z"), 1'b1);
		wait_settled();
	endtask

	// Receiver: random stalls, or a long hold when one is asked for.
	initial begin
		int unsigned n;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				n = hold_len;
				hold_len = 0;
				res_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				res_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compares every accepted result with the oldest one booked.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (verdicts_due.size() == 0) begin
				flag_mismatch($sformatf("result with nothing due: answer %0b status %0b",
					res_ch.answer, res_ch.status));
			end else begin
				want = verdicts_due.pop_front();
				if (res_ch.answer !== want.answer)
					flag_mismatch($sformatf("answer expected %0b actual %0b",
						want.answer, res_ch.answer));
				if (res_ch.status !== want.status)
					flag_mismatch($sformatf("status expected %0b actual %0b",
						want.status, res_ch.status));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.command = CMD_INSERT;
		item_ch.letter  = '0;
		item_ch.last    = 1'b0;
		foreach (trie_child[i])
			trie_child[i] = 0;
		foreach (trie_end[i])
			trie_end[i] = 1'b0;
		trie_used     = 1;
		walk_at       = 0;
		walk_lost     = 1'b0;
		pool_overflow = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(330, 18, 70);
		test_random(330, 70, 18);
		test_random(340, 0, 0);
		test_backpressure();
		test_pool_full();

		if (mismatches == 0 && verdicts_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
